>>> rtl/long_press_detector_progress_blink_assert.svh
// assertion macros for the long press detector
// used by the top level; expects signals clk and rst_n in scope
`ifndef LONG_PRESS_DETECTOR_PROGRESS_BLINK_ASSERT_SVH
`define LONG_PRESS_DETECTOR_PROGRESS_BLINK_ASSERT_SVH

// same-cycle implication
`define LPDPB_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("lpdpb assertion failed");

// next-cycle implication
`define LPDPB_ASSERT_NXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("lpdpb assertion failed");

`endif

>>> rtl/lpdpb_pkg.sv
// shared types, constants and the blink interval function
// no dependencies
package lpdpb_pkg;

    localparam int unsigned THRESH_W       = 20;
    localparam int unsigned TIME_W         = 32;
    localparam int unsigned PROG_W         = 7;
    localparam int unsigned DIVIDEND_W     = THRESH_W + PROG_W;
    localparam int unsigned DIVISOR_W      = THRESH_W + PROG_W - 1;
    localparam int unsigned DIV_STEPS      = PROG_W;
    localparam int unsigned STEP_W         = 3;
    localparam int unsigned INTERVAL_W     = 10;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 20'd5000;
    localparam int unsigned PCT_SCALE       = 100;
    localparam int unsigned BLINK_START_MS  = 500;
    localparam int unsigned BLINK_SLOPE_NUM = 45;
    localparam int unsigned BLINK_SLOPE_DEN = 10;
    localparam int unsigned BLINK_FLOOR_MS  = 50;
    // 45/10 per percent equals 9/2 exactly
    localparam int unsigned BLINK_SLOPE_X2  = BLINK_SLOPE_NUM * 2 / BLINK_SLOPE_DEN;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic div_start;
        logic div_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
    } dp_status_t;

    // blink interval in ms from progress in percent
    function automatic logic [INTERVAL_W-1:0] blink_interval(input logic [PROG_W-1:0] pct);
        logic [INTERVAL_W+1:0] scaled;
        logic [INTERVAL_W:0]   dec;
        logic [INTERVAL_W-1:0] ival;
        scaled = {{(INTERVAL_W+2-PROG_W){1'b0}}, pct} * (INTERVAL_W+2)'(BLINK_SLOPE_X2);
        dec    = scaled[INTERVAL_W+1:1];
        if (dec >= (INTERVAL_W+1)'(BLINK_START_MS))
            ival = '0;
        else
            ival = INTERVAL_W'((INTERVAL_W+1)'(BLINK_START_MS) - dec);
        if (ival < INTERVAL_W'(BLINK_FLOOR_MS))
            ival = INTERVAL_W'(BLINK_FLOOR_MS);
        return ival;
    endfunction

endpackage

>>> rtl/lpdpb_ctrl.sv
// sequencing state machine: accept, evaluate, divide, commit
// depends on lpdpb_pkg
module lpdpb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  lpdpb_pkg::dp_status_t  status,
    output lpdpb_pkg::ctrl_cmd_t   cmd
);
    import lpdpb_pkg::*;

    ctrl_state_t        state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                step_next = '0;
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                    state_next = ST_FIN;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // wait for the output slot
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/lpdpb_dpath.sv
// datapath: threshold register, press state, restoring divider, result register
// depends on lpdpb_pkg
module lpdpb_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpdpb_pkg::ctrl_cmd_t          cmd,
    output lpdpb_pkg::dp_status_t         status,
    input  logic                          cfg_we,
    input  logic [lpdpb_pkg::THRESH_W-1:0] cfg_data,
    input  logic                          in_button,
    input  logic [lpdpb_pkg::TIME_W-1:0]  in_now,
    output logic                          led_owned,
    output logic                          led_level,
    output logic                          reset_trigger
);
    import lpdpb_pkg::*;

    logic [THRESH_W-1:0]   thr_reg;
    logic [TIME_W-1:0]     press_reg, press_next;
    logic [TIME_W-1:0]     toggle_reg, toggle_next;
    logic                  was_held_reg, was_held_next;
    logic                  blink_reg, blink_next;
    logic                  btn_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [DIVIDEND_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [PROG_W-1:0]     quo_reg;
    logic                  owned_reg, level_reg, trig_reg;
    logic                  owned_next, level_next, trig_next;

    logic [TIME_W-1:0]     hold;
    logic                  at_thr;
    logic [TIME_W-1:0]     since_toggle;
    logic [INTERVAL_W-1:0] interval;
    logic                  fits;

    assign hold         = now_reg - press_reg;
    assign at_thr       = hold >= {{(TIME_W-THRESH_W){1'b0}}, thr_reg};
    assign since_toggle = now_reg - toggle_reg;
    assign interval     = blink_interval(quo_reg);
    assign fits         = rem_reg >= {1'b0, div_reg};

    assign status.need_div = btn_reg && was_held_reg && !at_thr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= THRESH_RESET;
            press_reg    <= '0;
            toggle_reg   <= '0;
            was_held_reg <= 1'b0;
            blink_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= cfg_data;
            if (cmd.commit)
            begin
                press_reg    <= press_next;
                toggle_reg   <= toggle_next;
                was_held_reg <= was_held_next;
                blink_reg    <= blink_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            btn_reg <= in_button;
            now_reg <= in_now;
        end
        if (cmd.div_start)
        begin
            // hold is below the threshold here, so the quotient fits in PROG_W bits
            rem_reg <= {{PROG_W{1'b0}}, hold[THRESH_W-1:0]} * DIVIDEND_W'(PCT_SCALE);
            div_reg <= {thr_reg, {(PROG_W-1){1'b0}}};
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (fits)
                rem_reg <= rem_reg - {1'b0, div_reg};
            div_reg <= div_reg >> 1;
            quo_reg <= {quo_reg[PROG_W-2:0], fits};
        end
        if (cmd.commit)
        begin
            owned_reg <= owned_next;
            level_reg <= level_next;
            trig_reg  <= trig_next;
        end
    end

    always_comb
    begin
        press_next    = press_reg;
        toggle_next   = toggle_reg;
        was_held_next = was_held_reg;
        blink_next    = blink_reg;
        owned_next    = 1'b0;
        level_next    = 1'b0;
        trig_next     = 1'b0;
        if (btn_reg)
        begin
            owned_next = 1'b1;
            if (!was_held_reg)
            begin
                press_next    = now_reg;
                toggle_next   = now_reg;
                was_held_next = 1'b1;
                blink_next    = 1'b1;
                level_next    = 1'b1;
            end
            else if (at_thr)
            begin
                level_next = 1'b1;
                trig_next  = 1'b1;
            end
            else
            begin
                if (since_toggle >= {{(TIME_W-INTERVAL_W){1'b0}}, interval})
                begin
                    toggle_next = now_reg;
                    blink_next  = !blink_reg;
                end
                level_next = blink_next;
            end
        end
        else
            was_held_next = 1'b0;
    end

    assign led_owned     = owned_reg;
    assign led_level     = level_reg;
    assign reset_trigger = trig_reg;

endmodule

>>> rtl/long_press_detector_progress_blink.sv
// top level of the long press detector with progress blink
// depends on lpdpb_pkg, lpdpb_ctrl, lpdpb_dpath and the assertion header
`include "long_press_detector_progress_blink_assert.svh"
//
// usage
//   one input beat is one poll of the reset button: its level and the ms
//   timestamp of the poll. every poll yields exactly one output beat
//   with led ownership, led level and the reset trigger flag
//   the cfg channel writes the hold threshold in ms; cfg_ready is always high,
//   writes belong in idle periods between polls
// sequence
//   a poll that needs no progress figure (released, first poll of a press,
//   threshold reached) goes from accept through the evaluate and finish states
//   to the output register; a poll below the threshold also passes through the
//   divide state, where the 7-step restoring divider forms hold*100/threshold
//   one quotient bit per cycle; one poll is in work at a time, so a new poll
//   is accepted only once the state machine is back in idle after a commit
// reset
//   rst_n clears the press state and the blink level, loads a threshold of
//   5000 ms and empties the output register
// stalls
//   a finished result sits in the output register until m_axis_tready; the
//   next poll is still accepted and worked on, and only its commit waits for
//   the output register to free up
module long_press_detector_progress_blink (
    input  logic        clk,
    input  logic        rst_n,
    // poll stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [0] button_pressed, [32:1] now_ms, rest zero
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] led_owned, [1] led_level, [2] reset_trigger
    // threshold write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data        // hold_threshold_ms
);
    import lpdpb_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       led_owned;
    logic       led_level;
    logic       reset_trigger;

    // the threshold register takes a write on any cycle
    assign cfg_ready = 1'b1;

    lpdpb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    lpdpb_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .in_button     (s_axis_tdata[0]),
        .in_now        (s_axis_tdata[TIME_W:1]),
        .led_owned     (led_owned),
        .led_level     (led_level),
        .reset_trigger (reset_trigger)
    );

    // result beat packing
    assign m_axis_tdata = {5'b0, reset_trigger, led_level, led_owned};

    // a trigger always comes with the led owned and driven on
    `LPDPB_ASSERT_IMP(a_trig_solid, m_axis_tvalid && reset_trigger, led_owned && led_level)
    // a released button never drives the led
    `LPDPB_ASSERT_IMP(a_release_dark, m_axis_tvalid && !led_owned, !led_level && !reset_trigger)
    // one poll at a time: no accept in the cycle after an accept
    `LPDPB_ASSERT_NXT(a_one_poll, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // a commit always leaves a valid result behind
    `LPDPB_ASSERT_NXT(a_commit_out, cmd.commit, m_axis_tvalid)

endmodule
